// ===== sv/stk_pkg.sv =====
// ----------------------------------------------------------------------------
// stk_pkg
// Types and codes shared by the sorted top-k insert block: request and
// response beats, the command codes and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
package stk_pkg;

   // Command codes carried in the request beat
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // Field widths fixed by the interface
   localparam int SCORE_W = 32;
   localparam int LEVEL_W = 16;
   localparam int NAME_W  = 64;
   localparam int RIDX_W  = 4;
   localparam int POS_W   = 4;
   localparam int CSR_W   = 5;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [SCORE_W-1:0] new_score;
      logic [LEVEL_W-1:0]        new_level;
      logic [NAME_W-1:0]         new_name;
      logic [RIDX_W-1:0]         read_index;
   } stk_req_type;

   typedef struct packed {
      logic                      accepted;
      logic [POS_W-1:0]          position;
      logic signed [SCORE_W-1:0] out_score;
      logic [LEVEL_W-1:0]        out_level;
      logic [NAME_W-1:0]         out_name;
      logic                      dirty;
   } stk_rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request beat
      logic execute;   // apply the command to the table and build the response
   } stk_ctl_type;

endpackage

// ===== sv/sorted_top_k_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_insert
// Descending-sorted table of the best entries with insert, read and clear.
// ----------------------------------------------------------------------------
// For each command the start beat is captured, the next cycle applies it
// to the row of compare-and-shift cells (one comparator per cell, all in
// parallel), and the cycle after that presents the result with rsp_valid
// high for exactly one cycle. busy is high while the command is applied and
// its result shown; a new command is taken only while busy is low. The
// receiver cannot stall; it must take each result in the cycle it is shown.
// The entry-count register may be written at any time (csr_ready is always
// high), but only while no command is in flight. The table and dirty flag are
// cleared by reset and by the clear command.
// ----------------------------------------------------------------------------
module sorted_top_k_insert
   import stk_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stk_req_type      req_data,
   output logic             rsp_valid,
   output stk_rsp_type      rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   stk_ctl_type ctl;

   assign csr_ready = 1'b1;

   stk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   stk_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_BYTES  (NAME_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/stk_ctrl.sv =====
// ----------------------------------------------------------------------------
// stk_ctrl
// Sequencer: captures a command, lets the datapath execute it, then issues
// the one-cycle response strobe.
// ----------------------------------------------------------------------------
module stk_ctrl
   import stk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output stk_ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Advance one step per cycle once a command is taken
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive commands and status
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign ctl.capture = (state_ff == ST_IDLE) && start;
   assign ctl.execute = (state_ff == ST_EXEC);

endmodule

// ===== sv/stk_datapath.sv =====
// ----------------------------------------------------------------------------
// stk_datapath
// Row of compare-and-shift cells holding the sorted table, the entry-count
// register, the dirty flag and the response register.
// ----------------------------------------------------------------------------
module stk_datapath
   import stk_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  stk_ctl_type      ctl,
   input  stk_req_type      req_data,
   input  logic             csr_write,
   input  logic [CSR_W-1:0] csr_data,
   output stk_rsp_type      rsp_data
);

   localparam int CELL_NAME_W = 8 * NAME_BYTES;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int N_W         = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int SUM_W       = CNT_W + POS_W;

   // Captured command; the name is trimmed at its first zero byte on capture
   stk_req_type              req_ff;
   logic [CELL_NAME_W-1:0]   name_ff;
   logic [CELL_NAME_W-1:0]   name_in;
   logic [CSR_W-1:0]         csr_ff;
   logic                     dirty_ff;
   logic                     dirty_in;
   stk_rsp_type              rsp_ff;
   stk_rsp_type              rsp_in;

   logic signed [SCORE_W-1:0] score_ff [TABLE_DEPTH];
   logic [LEVEL_W-1:0]        level_ff [TABLE_DEPTH];
   logic [CELL_NAME_W-1:0]    tag_ff   [TABLE_DEPTH];
   logic signed [SCORE_W-1:0] score_in [TABLE_DEPTH];
   logic [LEVEL_W-1:0]        level_in [TABLE_DEPTH];
   logic [CELL_NAME_W-1:0]    tag_in   [TABLE_DEPTH];

   logic [N_W-1:0]         used_n;
   logic [TABLE_DEPTH-1:0] beats;
   logic                   take;
   logic [SUM_W-1:0]       pos_sum;
   logic                   rd_hit;
   logic signed [SCORE_W-1:0] rd_score;
   logic [LEVEL_W-1:0]        rd_level;
   logic [CELL_NAME_W-1:0]    rd_name;

   // Trim the name: drop every byte from the first zero byte on
   always_comb begin
      logic alive;
      alive   = 1'b1;
      name_in = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (req_data.new_name[8*b +: 8] == 8'd0) alive = 1'b0;
         if (alive) name_in[8*b +: 8] = req_data.new_name[8*b +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff  <= req_data;
         name_ff <= name_in;
      end
   end

   // Entry-count register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_W'(16);
      end else if (csr_write) begin
         csr_ff <= csr_data;
      end
   end

   // Clamp the count to the table depth
   assign used_n = (N_W'(csr_ff) > N_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : N_W'(csr_ff);

   // Each in-use cell compares the candidate against its own score
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         beats[i] = (N_W'(i) < used_n) && (req_ff.new_score > score_ff[i]);
      end
   end

   // Table stays non-increasing, so any win means the last in-use cell lost
   assign take = |beats;

   // Position is the number of in-use cells that keep their place
   always_comb begin
      pos_sum = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if ((N_W'(i) < used_n) && !beats[i]) pos_sum = pos_sum + SUM_W'(1);
      end
   end

   // Read mux over the cells
   assign rd_hit = N_W'(req_ff.read_index) < used_n;
   always_comb begin
      rd_score = '0;
      rd_level = '0;
      rd_name  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (rd_hit && (N_W'(i) == N_W'(req_ff.read_index))) begin
            rd_score = score_ff[i];
            rd_level = level_ff[i];
            rd_name  = tag_ff[i];
         end
      end
   end

   // Cell update: hold, take the candidate, or shift down from the cell above
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         score_in[i] = score_ff[i];
         level_in[i] = level_ff[i];
         tag_in[i]   = tag_ff[i];
         if (ctl.execute && (req_ff.cmd == CMD_CLEAR)) begin
            score_in[i] = '0;
            level_in[i] = '0;
            tag_in[i]   = '0;
         end else if (ctl.execute && (req_ff.cmd == CMD_INSERT) && beats[i]) begin
            if (i == 0) begin
               score_in[i] = req_ff.new_score;
               level_in[i] = req_ff.new_level;
               tag_in[i]   = name_ff;
            end else if (!beats[(i == 0) ? 0 : i-1]) begin
               score_in[i] = req_ff.new_score;
               level_in[i] = req_ff.new_level;
               tag_in[i]   = name_ff;
            end else begin
               score_in[i] = score_ff[(i == 0) ? 0 : i-1];
               level_in[i] = level_ff[(i == 0) ? 0 : i-1];
               tag_in[i]   = tag_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            score_ff[i] <= '0;
            level_ff[i] <= '0;
            tag_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            score_ff[i] <= score_in[i];
            level_ff[i] <= level_in[i];
            tag_ff[i]   <= tag_in[i];
         end
      end
   end

   // Dirty flag and response
   always_comb begin
      dirty_in = dirty_ff;
      rsp_in   = '0;
      case (req_ff.cmd)
         CMD_INSERT: begin
            if (take) begin
               dirty_in        = 1'b1;
               rsp_in.accepted = 1'b1;
               rsp_in.position = pos_sum[POS_W-1:0];
            end
         end
         CMD_READ: begin
            rsp_in.out_score = rd_score;
            rsp_in.out_level = rd_level;
            rsp_in.out_name  = NAME_W'(rd_name);
         end
         CMD_CLEAR: dirty_in = 1'b0;
         default: dirty_in = dirty_ff;
      endcase
      rsp_in.dirty = dirty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
      end else if (ctl.execute) begin
         dirty_ff <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== test/stk_table_checker.sv =====
// ----------------------------------------------------------------------------
// stk_table_checker
// Watches the request, response and entry-count channels of the sorted
// top-k table, keeps its own copy of the table, predicts each response and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module stk_table_checker
   import stk_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  stk_req_type      req_data,
   input  logic             rsp_valid,
   input  stk_rsp_type      rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data,
   output int               fail_count,
   output int               outstanding
);

   // Shadow copy of the table
   logic signed [SCORE_W-1:0] score_row [TABLE_DEPTH];
   logic [LEVEL_W-1:0]        level_row [TABLE_DEPTH];
   logic [NAME_W-1:0]         name_row  [TABLE_DEPTH];
   logic                      dirty_seen;
   logic [CSR_W-1:0]          entry_limit;

   // Responses still owed by the block, oldest first
   stk_rsp_type owed_rsp [$];

   // Keep the low name bytes up to the first zero byte
   function automatic logic [NAME_W-1:0] tag_trim(logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] kept;
      logic [7:0]        ch;
      kept = '0;
      for (int b = 0; b < NAME_BYTES && b < 8; b++) begin
         ch = raw[8*b +: 8];
         if (ch == 8'd0) break;
         kept[8*b +: 8] = ch;
      end
      return kept;
   endfunction

   // Apply one command to the shadow table and build its response
   function automatic stk_rsp_type table_command(stk_req_type r);
      stk_rsp_type res;
      int          used;
      int          pos;
      res  = '0;
      used = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_limit);
      case (r.cmd)
         CMD_INSERT: begin
            if (used > 0 && $signed(r.new_score) > $signed(score_row[used-1])) begin
               pos = used - 1;
               while (pos > 0 && $signed(r.new_score) > $signed(score_row[pos-1])) begin
                  score_row[pos] = score_row[pos-1];
                  level_row[pos] = level_row[pos-1];
                  name_row[pos]  = name_row[pos-1];
                  pos--;
               end
               score_row[pos] = r.new_score;
               level_row[pos] = r.new_level;
               name_row[pos]  = tag_trim(r.new_name);
               dirty_seen     = 1'b1;
               res.accepted   = 1'b1;
               res.position   = POS_W'(pos);
            end
         end
         CMD_READ: begin
            if (int'(r.read_index) < used) begin
               res.out_score = score_row[r.read_index];
               res.out_level = level_row[r.read_index];
               res.out_name  = name_row[r.read_index];
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               score_row[i] = '0;
               level_row[i] = '0;
               name_row[i]  = '0;
            end
            dirty_seen = 1'b0;
         end
         default: ;
      endcase
      res.dirty = dirty_seen;
      return res;
   endfunction

   // Match responses, track the entry count, predict accepted beats
   always @(posedge clock) begin
      stk_rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            score_row[i] = '0;
            level_row[i] = '0;
            name_row[i]  = '0;
         end
         dirty_seen  = 1'b0;
         entry_limit = CSR_W'(16);
         owed_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_rsp.size() == 0) begin
               $error("response beat with nothing pending");
               fail_count++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data.accepted !== want.accepted) begin
                  $error("accepted mismatch: expected %0d, got %0d",
                         want.accepted, rsp_data.accepted);
                  fail_count++;
               end
               if (rsp_data.position !== want.position) begin
                  $error("position mismatch: expected %0d, got %0d",
                         want.position, rsp_data.position);
                  fail_count++;
               end
               if (rsp_data.out_score !== want.out_score) begin
                  $error("out_score mismatch: expected %0d, got %0d",
                         want.out_score, rsp_data.out_score);
                  fail_count++;
               end
               if (rsp_data.out_level !== want.out_level) begin
                  $error("out_level mismatch: expected %0d, got %0d",
                         want.out_level, rsp_data.out_level);
                  fail_count++;
               end
               if (rsp_data.out_name !== want.out_name) begin
                  $error("out_name mismatch: expected %h, got %h",
                         want.out_name, rsp_data.out_name);
                  fail_count++;
               end
               if (rsp_data.dirty !== want.dirty) begin
                  $error("dirty mismatch: expected %0d, got %0d",
                         want.dirty, rsp_data.dirty);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            entry_limit = csr_data;
         end
         if (start && !busy) begin
            owed_rsp.push_back(table_command(req_data));
         end
      end
      outstanding = owed_rsp.size();
   end

endmodule

// ===== test/sorted_top_k_insert_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_insert_tb
// Drives the sorted top-k table with directed and random commands over a
// series of entry counts, with random gaps between beats; the checker beside
// the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module sorted_top_k_insert_tb;
   import stk_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         PHASE_ITEMS  = 110;
   localparam int         PHASE_COUNT  = 10;
   localparam int         SETTLE_WAIT  = 4;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   stk_req_type      req_data;
   logic             rsp_valid;
   stk_rsp_type      rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data;
   int               fail_count;
   int               outstanding;

   // Entry counts walked through, extremes included
   int               limit_plan [PHASE_COUNT] = '{16, 0, 1, 2, 5, 17, 31, 8, 15, 16};
   bit               gaps_on;

   sorted_top_k_insert DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   stk_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run
   initial begin
      #5_000_000;
      $display("sorted_top_k_insert verification failed");
      $finish;
   end

   function automatic stk_req_type make_beat(logic [1:0] cmd, logic [31:0] score,
                                             logic [15:0] level, logic [63:0] name,
                                             logic [3:0] idx);
      stk_req_type b;
      b.cmd        = cmd;
      b.new_score  = score;
      b.new_level  = level;
      b.new_name   = name;
      b.read_index = idx;
      return b;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random command, weighted toward inserts with ties and extreme scores
   function automatic stk_req_type random_beat();
      stk_req_type b;
      int          r;
      logic [31:0] score;
      logic [63:0] name;
      r = $urandom_range(0, 99);
      if (r < 60)      b.cmd = CMD_INSERT;
      else if (r < 95) b.cmd = CMD_READ;
      else if (r < 98) b.cmd = CMD_CLEAR;
      else             b.cmd = CMD_UNUSED;
      r = $urandom_range(0, 9);
      if (r < 4)       score = $urandom;
      else if (r < 8)  score = $urandom_range(0, 64);
      else if (r == 8) score = 32'h7FFF_FFFF - $urandom_range(0, 3);
      else             score = 32'h8000_0000 + $urandom_range(0, 3);
      name = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) name[8*$urandom_range(0, 7) +: 8] = 8'd0;
      b.new_score  = score;
      b.new_level  = $urandom_range(0, 65535);
      b.new_name   = name;
      b.read_index = $urandom_range(0, 15);
      return b;
   endfunction

   // Present one beat after a gap and hold it until the block takes it
   task automatic send_beat(stk_req_type beat, int gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = beat;
      start    = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain all pending responses, then write the entry count
   task automatic write_limit(int value);
      start = 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = CSR_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      reset     = 1'b1;
      gaps_on   = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, ties, extremes, name ending, unused and clear
      send_beat(make_beat(CMD_READ,   32'd0,         16'd0,      64'd0, 4'd0), 0);
      send_beat(make_beat(CMD_INSERT, 32'h8000_0000, 16'd0,      64'd0, 4'd0), 0);
      send_beat(make_beat(CMD_INSERT, 32'd0,         16'd7,      64'h41, 4'd0), 1);
      send_beat(make_beat(CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF, '1, 4'hF), 0);
      send_beat(make_beat(CMD_INSERT, 32'd1, 16'd1, 64'h1122_3344_0055_6677, 4'd0), 2);
      send_beat(make_beat(CMD_INSERT, 32'd1, 16'd2, 64'h6261, 4'd0), 0);
      send_beat(make_beat(CMD_INSERT, 32'd100, 16'd3, 64'hFFFF_FFFF_FFFF_FF00, 4'd0), 0);
      for (int i = 0; i < 4; i++) begin
         send_beat(make_beat(CMD_READ, 32'd0, 16'd0, 64'd0, 4'(i)), 0);
      end
      send_beat(make_beat(CMD_READ,   32'd0, 16'd0, 64'd0, 4'hF), 0);
      send_beat(make_beat(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, '1, 4'hF), 0);
      send_beat(make_beat(CMD_CLEAR,  32'd0, 16'd0, 64'd0, 4'd0), 3);
      send_beat(make_beat(CMD_READ,   32'd0, 16'd0, 64'd0, 4'd0), 0);

      // One entry in use: replace, reject, read beyond use
      write_limit(1);
      send_beat(make_beat(CMD_INSERT, 32'd5, 16'd5, 64'h35, 4'd0), 0);
      send_beat(make_beat(CMD_INSERT, 32'd3, 16'd3, 64'h33, 4'd0), 0);
      send_beat(make_beat(CMD_INSERT, 32'd9, 16'd9, 64'h39, 4'd0), 0);
      send_beat(make_beat(CMD_READ,   32'd0, 16'd0, 64'd0, 4'd0), 0);
      send_beat(make_beat(CMD_READ,   32'd0, 16'd0, 64'd0, 4'd1), 0);

      // No entries in use: nothing is taken
      write_limit(0);
      send_beat(make_beat(CMD_INSERT, 32'h7FFF_FFFF, 16'd1, 64'h31, 4'd0), 0);
      send_beat(make_beat(CMD_READ,   32'd0, 16'd0, 64'd0, 4'd0), 0);

      // Count above the depth acts as the full depth
      write_limit(31);
      send_beat(make_beat(CMD_INSERT, 32'd42, 16'd4, 64'h4242, 4'd0), 0);
      send_beat(make_beat(CMD_READ,   32'd0, 16'd0, 64'd0, 4'hF), 0);

      // Random phases across entry counts, some with back-to-back beats
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_limit(limit_plan[p]);
         gaps_on = (p % 3) != 2;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_beat(random_beat(), pick_gap());
         end
      end

      // Drain and decide
      start = 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("sorted_top_k_insert verification clean");
      end else begin
         $display("sorted_top_k_insert verification failed");
      end
      $finish;
   end

endmodule
